### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; clocked on clk, RTMS_ASSERT is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge of clk, off during reset
`define RTMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// concurrent check that also holds while reset is applied
`define RTMS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/rtms_pkg.sv
// types, constants and table helpers of the ring target metropolis step
// no dependencies
package rtms_pkg;

	localparam int DIST_W = 32;                 // ring distance, unsigned Q8.24
	localparam int DIST_FRAC_BITS = 24;
	localparam int CNT_W = 32;
	localparam int SCALE_W = 19;
	localparam logic [SCALE_W-1:0] FIVE_OVER_LN2_Q16 = 19'd472742;
	localparam logic [15:0] ROUND_HALF_Q16 = 16'h8000;
	localparam logic [DIST_W-1:0] DIST_ONE_Q24 = 32'h0100_0000;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int SHIFT_LIMIT_BITS = 4;        // integer part below 16 keeps a threshold

	typedef struct packed {
		logic signed [15:0] step_x;
		logic signed [15:0] step_y;
		logic [15:0]        uniform_draw;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic               accepted;
		logic [CNT_W-1:0]   accepted_total;
	} out_beat_t;

	// r = 2^(-1/depth) in Q0.32, by bisection on r^depth against one half
	function automatic logic [63:0] pow2_ratio(input int depth);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] p;
		lo = 64'h0000_0000_8000_0000;
		hi = 64'h0000_0000_FFFF_FFFF;
		for (int it = 0; it < 34; it++) begin
			mid = lo + ((hi - lo) >> 1);
			p = 64'h0000_0001_0000_0000;
			for (int k = 0; k < depth; k++) begin
				p = (p * mid) >> 32;
			end
			if (p >= 64'h0000_0000_8000_0000) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	// entry k = r^k rounded to Q0.16, unit value clamped to all ones
	function automatic logic [15:0] pow2_entry(input logic [63:0] ratio, input int k);
		logic [63:0] t;
		logic [63:0] e;
		t = 64'h0000_0001_0000_0000;
		for (int j = 0; j < k; j++) begin
			t = (t * ratio) >> 32;
		end
		e = (t + 64'(ROUND_HALF_Q16)) >> 16;
		return (e > 64'h0000_0000_0000_FFFF) ? 16'hFFFF : e[15:0];
	endfunction

endpackage

### hw/rtl/rtms_stream_if.sv
// valid/ready stream channel carrying one payload beat
// depends on nothing; payload type is set where the channel is declared
interface rtms_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/ring_target_metropolis_step_top.sv
// random-walk metropolis step for the ring target exp(-5|x^2+y^2-1|)
// uses rtms_pkg, rtms_stream_if and assert_macros.svh
//
// usage:
//  - proposal channel (sink): one beat holds step_x, step_y (signed Q4.12)
//    and uniform_draw (unsigned Q0.16); taken when valid and ready are high
//  - result channel (source): one beat per proposal with the chain position
//    after the step (low 16 bits, Q4.12), the accept flag and a saturating
//    count of accepted steps
//  - a taken beat passes the input register, then the result register, before
//    it is offered on the result channel
//  - throughput: one beat per cycle while the result channel takes beats; the chain
//    position and distance close their loop combinationally through add, square,
//    distance compare, the constant scale of the distance step and the 2^-f table lookup
//  - reset clears the chain to the origin (distance one), the accept count
//    to zero and both stage valids; the 2^-f table is constant logic
//  - when the receiver stalls, the result register holds; the input register
//    still takes one more beat, then proposal.ready drops until the result
//    is taken
`include "assert_macros.svh"

module ring_target_metropolis_step_top #(
	parameter int POS_WIDTH = 16,
	parameter int EXP_TABLE_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	rtms_stream_if.sink   proposal,
	rtms_stream_if.source result
);

	localparam int SUM_W = ((POS_WIDTH > 16) ? POS_WIDTH : 16) + 1;
	localparam int SQ_W = 2 * POS_WIDTH;
	localparam int R2_W = ((SQ_W + 1) > 33) ? (SQ_W + 1) : 33;
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int PROD_W = rtms_pkg::DIST_W + rtms_pkg::SCALE_W + 1;
	localparam int EXPO_W = PROD_W - 16;
	localparam int FW_W = rtms_pkg::DIST_FRAC_BITS + IDX_W;
	localparam logic [63:0] POW2_RATIO = rtms_pkg::pow2_ratio(EXP_TABLE_DEPTH);
	localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((64'sd1 <<< (POS_WIDTH - 1)) - 1);
	localparam logic signed [SUM_W-1:0] POS_MIN = SUM_W'(-(64'sd1 <<< (POS_WIDTH - 1)));

	// 2^-f fraction table, constant logic
	logic [15:0] pow2_tbl [EXP_TABLE_DEPTH];
	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tbl
		assign pow2_tbl[g] = rtms_pkg::pow2_entry(POW2_RATIO, g);
	end

	// chain state
	logic signed [POS_WIDTH-1:0]   chain_x_q;
	logic signed [POS_WIDTH-1:0]   chain_y_q;
	logic [rtms_pkg::DIST_W-1:0]   dist_q;
	logic [rtms_pkg::CNT_W-1:0]    acc_cnt_q;

	// input register
	logic                          valid_s1;
	rtms_pkg::in_beat_t            beat_s1;

	// result register
	logic                          res_valid_q;
	rtms_pkg::out_beat_t           res_q;

	logic advance;
	logic take_in;

	// step datapath
	logic signed [SUM_W-1:0]       sum_x;
	logic signed [SUM_W-1:0]       sum_y;
	logic signed [POS_WIDTH-1:0]   prop_x;
	logic signed [POS_WIDTH-1:0]   prop_y;
	logic [POS_WIDTH-1:0]          mag_x;
	logic [POS_WIDTH-1:0]          mag_y;
	logic [SQ_W-1:0]               sq_x;
	logic [SQ_W-1:0]               sq_y;
	logic [R2_W-1:0]               r2;
	logic [R2_W-1:0]               one_r2;
	logic [R2_W-1:0]               diff;
	logic [rtms_pkg::DIST_W-1:0]   dist_new;
	logic [rtms_pkg::DIST_W-1:0]   delta;
	logic [PROD_W-1:0]             scaled;
	logic [EXPO_W-1:0]             expo;
	logic                          expo_big;
	logic [FW_W-1:0]               frac_idx;
	logic [IDX_W-1:0]              idx;
	logic [15:0]                   thr;
	logic                          closer;
	logic                          acc;
	logic signed [POS_WIDTH-1:0]   next_x;
	logic signed [POS_WIDTH-1:0]   next_y;
	logic signed [SUM_W-1:0]       next_x_ext;
	logic signed [SUM_W-1:0]       next_y_ext;
	logic [rtms_pkg::CNT_W-1:0]    next_cnt;

	// handshake: the input register moves on when the result register is free
	assign advance = valid_s1 && (!res_valid_q || result.ready);
	assign proposal.ready = !valid_s1 || advance;
	assign take_in = proposal.valid && proposal.ready;

	// proposed point, saturated to the position range
	assign sum_x = SUM_W'(chain_x_q) + SUM_W'(beat_s1.step_x);
	assign sum_y = SUM_W'(chain_y_q) + SUM_W'(beat_s1.step_y);

	always_comb begin
		if (sum_x > POS_MAX) begin
			prop_x = POS_WIDTH'(POS_MAX);
		end else if (sum_x < POS_MIN) begin
			prop_x = POS_WIDTH'(POS_MIN);
		end else begin
			prop_x = POS_WIDTH'(sum_x);
		end
		if (sum_y > POS_MAX) begin
			prop_y = POS_WIDTH'(POS_MAX);
		end else if (sum_y < POS_MIN) begin
			prop_y = POS_WIDTH'(POS_MIN);
		end else begin
			prop_y = POS_WIDTH'(sum_y);
		end
	end

	// ring distance |x^2 + y^2 - 1| in Q8.24, saturated to 32 bits
	assign mag_x = prop_x[POS_WIDTH-1] ? POS_WIDTH'(-prop_x) : POS_WIDTH'(prop_x);
	assign mag_y = prop_y[POS_WIDTH-1] ? POS_WIDTH'(-prop_y) : POS_WIDTH'(prop_y);
	assign sq_x = SQ_W'(mag_x) * SQ_W'(mag_x);
	assign sq_y = SQ_W'(mag_y) * SQ_W'(mag_y);
	assign r2 = R2_W'(sq_x) + R2_W'(sq_y);
	assign one_r2 = R2_W'(rtms_pkg::DIST_ONE_Q24);
	assign diff = (r2 >= one_r2) ? (r2 - one_r2) : (one_r2 - r2);
	assign dist_new = (|diff[R2_W-1:rtms_pkg::DIST_W]) ? '1 : diff[rtms_pkg::DIST_W-1:0];

	// exponent a = delta * 5/ln2, rounded; threshold = table[frac] >> int(a)
	assign closer = dist_new <= dist_q;
	assign delta = dist_new - dist_q;
	assign scaled = PROD_W'(delta) * PROD_W'(rtms_pkg::FIVE_OVER_LN2_Q16)
		+ PROD_W'(rtms_pkg::ROUND_HALF_Q16);
	assign expo = scaled[PROD_W-1:16];
	assign expo_big = |expo[EXPO_W-1:rtms_pkg::DIST_FRAC_BITS + rtms_pkg::SHIFT_LIMIT_BITS];
	assign frac_idx = FW_W'(expo[rtms_pkg::DIST_FRAC_BITS-1:0]) * FW_W'(EXP_TABLE_DEPTH);
	assign idx = frac_idx[FW_W-1:rtms_pkg::DIST_FRAC_BITS];
	assign thr = pow2_tbl[idx]
		>> expo[rtms_pkg::DIST_FRAC_BITS +: rtms_pkg::SHIFT_LIMIT_BITS];
	assign acc = closer || (!expo_big && (beat_s1.uniform_draw < thr));

	// state after this step
	assign next_x = acc ? prop_x : chain_x_q;
	assign next_y = acc ? prop_y : chain_y_q;
	assign next_x_ext = SUM_W'(next_x);
	assign next_y_ext = SUM_W'(next_y);
	assign next_cnt = (acc && (acc_cnt_q != rtms_pkg::CNT_MAX)) ? acc_cnt_q + 1'b1 : acc_cnt_q;

	// control and chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			chain_x_q <= '0;
			chain_y_q <= '0;
			dist_q <= rtms_pkg::DIST_ONE_Q24;
			acc_cnt_q <= '0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (advance && acc) begin
				chain_x_q <= prop_x;
				chain_y_q <= prop_y;
				dist_q <= dist_new;
				acc_cnt_q <= next_cnt;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			beat_s1 <= proposal.data;
		end
		if (advance) begin
			res_q.pos_x <= next_x_ext[15:0];
			res_q.pos_y <= next_y_ext[15:0];
			res_q.accepted <= acc;
			res_q.accepted_total <= next_cnt;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data = res_q;

	// checks
	`RTMS_ASSERT(a_cnt_monotonic, ##1 (acc_cnt_q >= $past(acc_cnt_q)), "accept count went down")
	`RTMS_ASSERT(a_chain_holds, !(advance && acc) |=> ($stable(chain_x_q) && $stable(chain_y_q) && $stable(dist_q)), "chain moved without an accepted beat")
	`RTMS_ASSERT(a_result_follows, advance |=> (res_valid_q && (res_q.accepted_total == acc_cnt_q)), "result beat does not match chain count")

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// testbench for ring_target_metropolis_step_top: random-walk metropolis steps on the ring target
// depends on rtms_pkg, rtms_stream_if and the block itself; predicts every result beat
// in-house and compares it field by field on the result channel
module tb_top;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TABLE_DEPTH = 64;
	localparam int POS_MAX = 32767;
	localparam int POS_MIN = -32768;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rtms_stream_if #(.payload_t(rtms_pkg::in_beat_t)) proposal_ch ();
	rtms_stream_if #(.payload_t(rtms_pkg::out_beat_t)) result_ch ();

	ring_target_metropolis_step_top #(
		.POS_WIDTH(16),
		.EXP_TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.proposal(proposal_ch),
		.result(result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// chain state as the predictor sees it
	logic signed [15:0]          walk_x;
	logic signed [15:0]          walk_y;
	logic [rtms_pkg::DIST_W-1:0] walk_dist;
	logic [rtms_pkg::CNT_W-1:0]  walk_count;
	logic [15:0]                 exp2_frac [TABLE_DEPTH];

	rtms_pkg::out_beat_t expected_q[$];
	int mismatch_count = 0;
	int cycle_count = 0;

	// shared between the stimulus and the result sink
	bit idle_on = 1'b1;
	bit hold_request = 1'b0;

	// 2^-(k/depth) in Q0.16: find the per-entry ratio in Q0.32 by bisection,
	// then walk its powers, rounding each to 16 bits with the unit entry clamped
	function automatic void build_exp2_frac();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] pw;
		logic [63:0] rounded;
		lo = 64'h0000_0000_8000_0000;
		hi = 64'h0000_0000_FFFF_FFFF;
		repeat (34) begin
			mid = lo + ((hi - lo) >> 1);
			pw = 64'h0000_0001_0000_0000;
			repeat (TABLE_DEPTH) pw = (pw * mid) >> 32;
			if (pw >= 64'h0000_0000_8000_0000) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end
		pw = 64'h0000_0001_0000_0000;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			rounded = (pw + 64'(rtms_pkg::ROUND_HALF_Q16)) >> 16;
			exp2_frac[k] = (rounded > 64'h0000_0000_0000_FFFF) ? 16'hFFFF : rounded[15:0];
			pw = (pw * lo) >> 32;
		end
	endfunction

	// one metropolis step on the predictor's chain; returns the result beat it must produce
	function automatic rtms_pkg::out_beat_t metropolis_predict(input rtms_pkg::in_beat_t b);
		int nx;
		int ny;
		longint r2;
		longint gap;
		logic [rtms_pkg::DIST_W-1:0] dn;
		logic [rtms_pkg::DIST_W-1:0] delta;
		logic [31:0] thr;
		logic [63:0] a;
		logic [63:0] a_int;
		logic [63:0] a_idx;
		logic take;
		rtms_pkg::out_beat_t r;

		// proposed point, each coordinate clamped to the 16-bit signed range
		nx = int'(walk_x) + int'($signed(b.step_x));
		ny = int'(walk_y) + int'($signed(b.step_y));
		if (nx > POS_MAX) nx = POS_MAX;
		else if (nx < POS_MIN) nx = POS_MIN;
		if (ny > POS_MAX) ny = POS_MAX;
		else if (ny < POS_MIN) ny = POS_MIN;

		// ring distance |x^2 + y^2 - 1| in Q8.24
		r2 = longint'(nx) * longint'(nx) + longint'(ny) * longint'(ny);
		if (r2 >= longint'(rtms_pkg::DIST_ONE_Q24)) gap = r2 - longint'(rtms_pkg::DIST_ONE_Q24);
		else gap = longint'(rtms_pkg::DIST_ONE_Q24) - r2;
		dn = (gap > 64'sh0000_0000_FFFF_FFFF) ? '1 : gap[31:0];

		if (dn <= walk_dist) begin
			// distance does not grow: always taken
			take = 1'b1;
		end else begin
			// exp(-5*delta) = 2^-a, a = delta * 5/ln2 rounded half up
			delta = dn - walk_dist;
			a = (64'(delta) * 64'(rtms_pkg::FIVE_OVER_LN2_Q16)
				+ 64'(rtms_pkg::ROUND_HALF_Q16)) >> 16;
			a_int = a >> rtms_pkg::DIST_FRAC_BITS;
			a_idx = ((a & 64'h0000_0000_00FF_FFFF) * TABLE_DEPTH) >> rtms_pkg::DIST_FRAC_BITS;
			thr = '0;
			if (a_int < 16 && a_idx < TABLE_DEPTH) thr = 32'(exp2_frac[a_idx]) >> a_int;
			take = (32'(b.uniform_draw) < thr);
		end

		if (take) begin
			walk_x = 16'(nx);
			walk_y = 16'(ny);
			walk_dist = dn;
			if (walk_count != rtms_pkg::CNT_MAX) walk_count = walk_count + 1'b1;
		end

		r.pos_x = walk_x;
		r.pos_y = walk_y;
		r.accepted = take;
		r.accepted_total = walk_count;
		return r;
	endfunction

	// offer one proposal beat, with a random idle burst in front of it while idling is on;
	// returns right after the accepting edge with valid still high
	task automatic send_proposal(input logic [15:0] sx, input logic [15:0] sy,
			input logic [15:0] draw);
		rtms_pkg::in_beat_t b;
		int gap;
		b.step_x = sx;
		b.step_y = sy;
		b.uniform_draw = draw;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			proposal_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		proposal_ch.valid <= 1'b1;
		proposal_ch.data <= b;
		// sampled right at the edge, before the block's own updates land
		do @(posedge clk); while (!proposal_ch.ready);
		expected_q = {expected_q, metropolis_predict(b)};
	endtask

	// sender goes quiet and waits for every outstanding result beat
	task automatic wait_for_results();
		@(negedge clk);
		proposal_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// mostly short moves so the chain wanders around the ring,
	// now and then a long jump or a full-range value
	function automatic logic [15:0] rand_step();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 16383)) - 16'd8192;
			default: return 16'($urandom_range(0, 2047)) - 16'd1024;
		endcase
	endfunction

	function automatic logic [15:0] rand_draw();
		case ($urandom_range(0, 15))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// hand-picked steps; the chain starts at the origin, distance one
	task automatic test_directed();
		send_proposal(16'h0000, 16'h0000, 16'h0000);  // same point, equal distance is taken
		send_proposal(16'h1000, 16'h0000, 16'hFFFF);  // onto the ring at x = 1.0, distance zero
		send_proposal(16'h0001, 16'h0000, 16'hFFFF);  // tiny uphill move, unit entry: top draw loses
		send_proposal(16'h0001, 16'h0000, 16'hFFFE);  // same move, draw just under the unit entry
		send_proposal(16'hFFFF, 16'h0000, 16'h0000);  // back down onto the ring
		send_proposal(16'hE000, 16'h0000, 16'hFFFF);  // jump to x = -1.0, equal distance
		send_proposal(16'h7FFF, 16'h7FFF, 16'h0000);  // far out, y lands on the top value, exponent too large
		send_proposal(16'h8000, 16'h8000, 16'h0000);  // x clamps low, y lands on the bottom value, rejected
		send_proposal(16'h0400, 16'h0000, 16'h0000);  // moderate climb, mid-table threshold
		send_proposal(16'h0400, 16'h0000, 16'hFFFF);  // climb again, top draw
		send_proposal(16'h0000, 16'h1000, 16'h8000);
		send_proposal(16'h7FFF, 16'h0000, 16'hFFFF);
		send_proposal(16'h8000, 16'h0000, 16'hFFFF);
		send_proposal(16'h0000, 16'h7FFF, 16'h0001);
		send_proposal(16'h0000, 16'h8000, 16'h0000);
		send_proposal(16'hFFFF, 16'hFFFF, 16'h5555);
		send_proposal(16'h5555, 16'hAAAA, 16'hAAAA);
		send_proposal(16'hAAAA, 16'h5555, 16'h5555);
		send_proposal(16'h0100, 16'hFF00, 16'h0000);
		send_proposal(16'h0000, 16'h0000, 16'hFFFF);
		wait_for_results();
	endtask

	// long random walk with idling on both sides
	task automatic test_random_walk();
		repeat (1400) send_proposal(rand_step(), rand_step(), rand_draw());
		wait_for_results();
	endtask

	// result side holds off for a long stretch while proposals keep coming,
	// so the pipeline fills and proposal.ready drops
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_request = 1'b1;
		repeat (40) send_proposal(rand_step(), rand_step(), rand_draw());
		wait_for_results();
		idle_on = 1'b1;
	endtask

	// closing stretch at full rate, no idling anywhere
	task automatic test_streaming();
		idle_on = 1'b0;
		repeat (560) send_proposal(rand_step(), rand_step(), rand_draw());
		wait_for_results();
	endtask

	// result sink: random stall bursts, plus one long hold on request
	initial begin : result_sink
		int stall;
		int long_hold;
		stall = 0;
		long_hold = 0;
		result_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				long_hold = LONG_HOLD_CYCLES;
			end
			if (long_hold > 0) begin
				result_ch.ready <= 1'b0;
				long_hold--;
			end else if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				// stall burst, this cycle included
				stall = $urandom_range(1, 10) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// every result beat taken is checked against the oldest prediction
	always @(posedge clk) begin
		rtms_pkg::out_beat_t got;
		rtms_pkg::out_beat_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_q.size() == 0) begin
				$error("result beat with no prediction waiting: pos_x %0d pos_y %0d",
					got.pos_x, got.pos_y);
				mismatch_count++;
			end else begin
				want = expected_q.pop_front();
				if (got.pos_x !== want.pos_x) begin
					$error("pos_x: expected %0d, actual %0d", want.pos_x, got.pos_x);
					mismatch_count++;
				end
				if (got.pos_y !== want.pos_y) begin
					$error("pos_y: expected %0d, actual %0d", want.pos_y, got.pos_y);
					mismatch_count++;
				end
				if (got.accepted !== want.accepted) begin
					$error("accepted: expected %0b, actual %0b", want.accepted, got.accepted);
					mismatch_count++;
				end
				if (got.accepted_total !== want.accepted_total) begin
					$error("accepted_total: expected %0d, actual %0d",
						want.accepted_total, got.accepted_total);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		proposal_ch.valid = 1'b0;
		proposal_ch.data = '0;

		// predictor comes out of reset with the chain at the origin
		build_exp2_frac();
		walk_x = '0;
		walk_y = '0;
		walk_dist = rtms_pkg::DIST_ONE_Q24;
		walk_count = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_walk();
		test_backpressure();
		test_streaming();

		// let any stray beat show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
